// ----- hw/rtl/fmpf_pkg.sv -----
// Package for the first-match packet filter: request and response structs,
// operation and chain codes, and the front-to-back command type.
// No dependencies.
package fmpf_pkg;

   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [1:0] CHAIN_INPUT   = 2'd0;
   localparam logic [1:0] CHAIN_OUTPUT  = 2'd1;
   localparam logic [1:0] CHAIN_FORWARD = 2'd2;
   localparam logic [1:0] CHAIN_NONE    = 2'd3;
   localparam int         NUM_CHAINS    = 3;

   localparam logic [1:0] CSR_POLICY_INPUT   = 2'd0;
   localparam logic [1:0] CSR_POLICY_OUTPUT  = 2'd1;
   localparam logic [1:0] CSR_POLICY_FORWARD = 2'd2;

   // Width of one stored rule: addresses, masks, protocol, ports, target.
   localparam int RULE_W = 32 * 4 + 8 + 16 + 16 + 1;

   typedef struct packed {
      logic        operation;
      logic [1:0]  chain_select;
      logic [31:0] src_ip;
      logic [31:0] src_netmask;
      logic [31:0] dst_ip;
      logic [31:0] dst_netmask;
      logic [7:0]  proto_num;
      logic [15:0] src_l4port;
      logic [15:0] dst_l4port;
      logic        rule_target;
      logic        has_ip_header;
      logic        has_transport;
   } req_type;

   typedef struct packed {
      logic       verdict;
      logic       status;
      logic       rule_hit;
      logic [5:0] hit_slot;
   } rsp_type;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] smask;
      logic [31:0] dip;
      logic [31:0] dmask;
      logic [7:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        target;
   } rule_type;

   // Classified command handed from the front end to the scan engine.
   typedef struct packed {
      logic       is_add;      // add with a free slot
      logic       is_scan;     // classify on a real chain
      logic [1:0] chain;
      logic [5:0] slot;        // slot to write for an add
      logic       policy;      // chain default verdict
      req_type    req;
   } cmd_type;

endpackage

// ----- hw/rtl/fmpf_front.sv -----
// Front end of the packet filter: accepts requests, keeps the per-chain
// rule counts and policy registers, and hands classified commands onward.
// Depends on fmpf_pkg.
module fmpf_front #(
   parameter int RULES_PER_CHAIN = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  fmpf_pkg::req_type  req_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [0:0]         csr_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output fmpf_pkg::cmd_type  cmd_data
);
   localparam int CW = $clog2(RULES_PER_CHAIN + 1);

   logic [CW-1:0] count_ff [fmpf_pkg::NUM_CHAINS];
   logic [CW-1:0] count_in [fmpf_pkg::NUM_CHAINS];
   logic [fmpf_pkg::NUM_CHAINS-1:0] policy_ff, policy_in;
   logic              cmd_valid_ff, cmd_valid_in;
   fmpf_pkg::cmd_type cmd_ff, cmd_in;
   logic              accept;
   logic [CW-1:0]     cur_count;
   logic              chain_ok;

   assign req_full  = cmd_valid_ff && !cmd_ready;
   assign accept    = req_push && !req_full;
   assign cmd_valid = cmd_valid_ff;
   assign cmd_data  = cmd_ff;
   assign chain_ok  = req_data.chain_select != fmpf_pkg::CHAIN_NONE;
   assign cur_count = chain_ok ? count_ff[req_data.chain_select] : '0;

   // Apply policy writes and classify the request; slots fill in order so the count is the free slot.
   always_comb begin
      count_in     = count_ff;
      policy_in    = policy_ff;
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      cmd_in       = cmd_ff;
      if (csr_write) begin
         case (csr_index)
            fmpf_pkg::CSR_POLICY_INPUT:   policy_in[0] = csr_data[0];
            fmpf_pkg::CSR_POLICY_OUTPUT:  policy_in[1] = csr_data[0];
            fmpf_pkg::CSR_POLICY_FORWARD: policy_in[2] = csr_data[0];
            default: ;
         endcase
      end
      if (accept) begin
         cmd_valid_in   = 1'b1;
         cmd_in.req     = req_data;
         cmd_in.chain   = req_data.chain_select;
         cmd_in.slot    = 6'(cur_count);
         cmd_in.policy  = chain_ok ? policy_ff[req_data.chain_select] : 1'b0;
         cmd_in.is_add  = (req_data.operation == fmpf_pkg::OP_ADD) && chain_ok &&
                          (cur_count < CW'(RULES_PER_CHAIN));
         cmd_in.is_scan = (req_data.operation == fmpf_pkg::OP_CLASSIFY) && chain_ok;
         if (cmd_in.is_add) begin
            count_in[req_data.chain_select] = cur_count + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < fmpf_pkg::NUM_CHAINS; c++) begin
            count_ff[c] <= '0;
         end
         policy_ff    <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         policy_ff    <= policy_in;
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   chk_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CW'(RULES_PER_CHAIN) && count_ff[1] <= CW'(RULES_PER_CHAIN) &&
      count_ff[2] <= CW'(RULES_PER_CHAIN))
      else $error("rule count above chain size");
   chk_hold: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff && !cmd_ready |=> cmd_valid_ff && $stable(cmd_ff))
      else $error("stalled command changed");
   chk_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff |-> !(cmd_ff.is_add && cmd_ff.is_scan))
      else $error("command both add and scan");
endmodule

// ----- hw/rtl/fmpf_engine.sv -----
// Back end of the packet filter: rule memory, one-rule-per-cycle scan and
// the response register. Depends on fmpf_pkg.
module fmpf_engine #(
   parameter int RULES_PER_CHAIN = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  fmpf_pkg::cmd_type cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fmpf_pkg::rsp_type rsp_data
);
   localparam int SW    = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
   localparam int DEPTH = fmpf_pkg::NUM_CHAINS * RULES_PER_CHAIN;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(RULES_PER_CHAIN + 1);

   typedef enum logic [1:0] {
      ST_IDLE, ST_READ, ST_CHECK, ST_DONE
   } state_type;

   logic [fmpf_pkg::RULE_W-1:0] mem [DEPTH];
   logic [fmpf_pkg::RULE_W-1:0] rd_ff;
   logic [RULES_PER_CHAIN-1:0]  valid_ff [fmpf_pkg::NUM_CHAINS];
   state_type         state_ff;
   fmpf_pkg::cmd_type cur_ff;
   logic [CW-1:0]     idx_ff;
   logic [SW-1:0]     chk_ff;
   logic              rsp_valid_ff;
   fmpf_pkg::rsp_type rsp_ff;
   fmpf_pkg::rule_type rule;
   logic              match;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              take;
   logic [1:0]        cmd_chain;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign take      = cmd_valid && cmd_ready;
   assign rule      = fmpf_pkg::rule_type'(rd_ff);
   assign cmd_chain = (cmd_data.chain == fmpf_pkg::CHAIN_NONE) ? 2'd0 : cmd_data.chain;
   assign wr_addr   = AW'(cmd_chain * RULES_PER_CHAIN) + AW'(cmd_data.slot);
   assign rd_addr   = AW'(cur_ff.chain * RULES_PER_CHAIN) + AW'(idx_ff);

   // Match the registered rule against the packet fields.
   always_comb begin
      match = cur_ff.req.has_ip_header;
      if (rule.sip != '0 &&
          ((cur_ff.req.src_ip & rule.smask) != (rule.sip & rule.smask))) match = 1'b0;
      if (rule.dip != '0 &&
          ((cur_ff.req.dst_ip & rule.dmask) != (rule.dip & rule.dmask))) match = 1'b0;
      if (rule.proto != '0 && cur_ff.req.proto_num != rule.proto) match = 1'b0;
      if (cur_ff.req.has_transport) begin
         if (rule.sport != '0 && cur_ff.req.src_l4port != rule.sport) match = 1'b0;
         if (rule.dport != '0 && cur_ff.req.dst_l4port != rule.dport) match = 1'b0;
      end else if (rule.sport != '0 || rule.dport != '0) begin
         match = 1'b0;
      end
   end

   // Rule memory: written by an add, read one slot per cycle during a scan.
   always_ff @(posedge clock) begin
      if (take && cmd_data.is_add) begin
         mem[wr_addr] <= {cmd_data.req.src_ip, cmd_data.req.src_netmask,
                          cmd_data.req.dst_ip, cmd_data.req.dst_netmask,
                          cmd_data.req.proto_num, cmd_data.req.src_l4port,
                          cmd_data.req.dst_l4port, cmd_data.req.rule_target};
      end
      rd_ff <= mem[rd_addr];
   end

   // Sequencer: read slot, check it in the following cycle, stop on first hit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < fmpf_pkg::NUM_CHAINS; c++) begin
            valid_ff[c] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  cur_ff <= cmd_data;
                  idx_ff <= '0;
                  if (cmd_data.is_add) begin
                     valid_ff[cmd_chain][SW'(cmd_data.slot)] <= 1'b1;
                  end
                  if (cmd_data.is_scan) begin
                     state_ff <= ST_READ;
                  end else begin
                     // Only an add that found no room or named no chain sets the status bit.
                     rsp_ff.verdict  <= 1'b0;
                     rsp_ff.status   <= (cmd_data.req.operation == fmpf_pkg::OP_ADD) &&
                                        !cmd_data.is_add;
                     rsp_ff.rule_hit <= 1'b0;
                     rsp_ff.hit_slot <= cmd_data.is_add ? cmd_data.slot : 6'd0;
                     rsp_valid_ff    <= 1'b1;
                  end
               end
            end
            ST_READ: begin
               chk_ff   <= SW'(idx_ff);
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (valid_ff[cur_ff.chain][chk_ff] && match) begin
                  rsp_ff.verdict  <= rule.target;
                  rsp_ff.rule_hit <= 1'b1;
                  rsp_ff.hit_slot <= 6'(chk_ff);
                  state_ff        <= ST_DONE;
               end else if (idx_ff == CW'(RULES_PER_CHAIN)) begin
                  rsp_ff.verdict  <= cur_ff.policy;
                  rsp_ff.rule_hit <= 1'b0;
                  rsp_ff.hit_slot <= 6'd0;
                  state_ff        <= ST_DONE;
               end else begin
                  chk_ff   <= SW'(idx_ff);
                  idx_ff   <= idx_ff + CW'(1);
               end
            end
            ST_DONE: begin
               rsp_ff.status <= 1'b0;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   chk_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd_ready)
      else $error("command taken while scanning");
   chk_done_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("scan finished without response");
   chk_hit_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && match && valid_ff[cur_ff.chain][chk_ff] |=> state_ff == ST_DONE)
      else $error("first hit missed");
endmodule

// ----- hw/rtl/first_match_packet_filter.sv -----
// First-match packet filter, top level. An add is answered once the front
// register has passed it on and the engine has registered the response; a classify
// reads one rule per cycle through the single read port of the rule memory and
// answers at the first hit, or with the chain policy when none does.
// One request is worked on at a time; a second waits in the front register and
// enters the engine once the previous response has been popped.
// Synchronous reset clears rule valid bits, rule counts and the policies.
// Depends on fmpf_pkg, fmpf_front and fmpf_engine.
module first_match_packet_filter #(
   parameter int RULES_PER_CHAIN = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  fmpf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fmpf_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [0:0]        csr_data
);
   logic              cmd_valid, cmd_ready;
   fmpf_pkg::cmd_type cmd_data;

   fmpf_front #(.RULES_PER_CHAIN(RULES_PER_CHAIN)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .csr_write, .csr_index, .csr_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   fmpf_engine #(.RULES_PER_CHAIN(RULES_PER_CHAIN)) u_engine (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

// ----- tb/tb_first_match_packet_filter.sv -----
// Self-checking testbench for first_match_packet_filter: directed and random
// rule adds and packet classifies, checked against a local model of the chains.
// Depends on fmpf_pkg and the first_match_packet_filter RTL.
module tb_first_match_packet_filter;

   localparam int RPC = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 2 * RPC + 10;

   // Scoreboard: holds a copy of the rule chains and the expected responses.
   class filter_scoreboard;
      fmpf_pkg::rule_type rules[fmpf_pkg::NUM_CHAINS][RPC];
      bit                 valid[fmpf_pkg::NUM_CHAINS][RPC];
      int                 count[fmpf_pkg::NUM_CHAINS];
      bit                 policy[fmpf_pkg::NUM_CHAINS];
      fmpf_pkg::rsp_type  pending[$];
      int                 errors;

      function new();
         errors = 0;
         for (int c = 0; c < fmpf_pkg::NUM_CHAINS; c++) begin
            count[c] = 0;
            policy[c] = 1'b0;
            for (int s = 0; s < RPC; s++) valid[c][s] = 1'b0;
         end
      endfunction

      function bit rule_hits(fmpf_pkg::rule_type r, fmpf_pkg::req_type q);
         if (!q.has_ip_header) return 1'b0;
         if (r.sip != 0 && (q.src_ip & r.smask) != (r.sip & r.smask)) return 1'b0;
         if (r.dip != 0 && (q.dst_ip & r.dmask) != (r.dip & r.dmask)) return 1'b0;
         if (r.proto != 0 && q.proto_num != r.proto) return 1'b0;
         if (q.has_transport) begin
            if (r.sport != 0 && q.src_l4port != r.sport) return 1'b0;
            if (r.dport != 0 && q.dst_l4port != r.dport) return 1'b0;
         end else if (r.sport != 0 || r.dport != 0) begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(fmpf_pkg::req_type q);
         fmpf_pkg::rsp_type e;
         int                c;
         e = '0;
         c = q.chain_select;
         if (q.operation == fmpf_pkg::OP_ADD) begin
            e.status = 1'b1;
            if (q.chain_select != fmpf_pkg::CHAIN_NONE && count[c] < RPC) begin
               for (int s = 0; s < RPC; s++) begin
                  if (!valid[c][s]) begin
                     rules[c][s] = '{q.src_ip, q.src_netmask, q.dst_ip, q.dst_netmask,
                                     q.proto_num, q.src_l4port, q.dst_l4port,
                                     q.rule_target};
                     valid[c][s] = 1'b1;
                     count[c]++;
                     e.status = 1'b0;
                     e.hit_slot = 6'(s);
                     break;
                  end
               end
            end
         end else if (q.chain_select != fmpf_pkg::CHAIN_NONE) begin
            e.verdict = policy[c];
            for (int s = 0; s < RPC; s++) begin
               if (valid[c][s] && rule_hits(rules[c][s], q)) begin
                  e.verdict = rules[c][s].target;
                  e.rule_hit = 1'b1;
                  e.hit_slot = 6'(s);
                  break;
               end
            end
         end
         pending.push_back(e);
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(fmpf_pkg::rsp_type a);
         fmpf_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.verdict !== e.verdict) begin
            $error("verdict: expected %0d, actual %0d", e.verdict, a.verdict);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status);
            errors++;
         end
         if (a.rule_hit !== e.rule_hit) begin
            $error("rule_hit: expected %0d, actual %0d", e.rule_hit, a.rule_hit);
            errors++;
         end
         if (a.hit_slot !== e.hit_slot) begin
            $error("hit_slot: expected %0d, actual %0d", e.hit_slot, a.hit_slot);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   fmpf_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   fmpf_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [0:0]        csr_data = '0;

   filter_scoreboard sb = new();
   bit  hold_rsp = 1'b0;
   int  idle_cycles = 0;
   // Pool of addresses used by rules, so random packets hit them often.
   logic [31:0] addr_pool[8];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   first_match_packet_filter #(.RULES_PER_CHAIN(RPC)) uut (
      .clock, .reset, .req_push, .req_full, .req_data,
      .rsp_empty, .rsp_pop, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   // Sample both handshakes at the rising edge; feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_request(req_data);
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_first_match_packet_filter: done, errors");
            $finish;
         end
      end
   end

   // Push one request, then wait a random gap unless no_gap is set.
   task automatic send_request(fmpf_pkg::req_type q, bit no_gap = 1'b0);
      int gap;
      req_data <= q;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic stop_push();
      req_push <= 1'b0;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_policy(logic [1:0] idx, bit v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.policy[idx] = v;
   endtask

   // Fully random request bits.
   function automatic fmpf_pkg::req_type random_bits();
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(fmpf_pkg::req_type)-1:0];
   endfunction

   function automatic fmpf_pkg::req_type random_add(logic [1:0] ch);
      fmpf_pkg::req_type q;
      q = random_bits();
      q.operation = fmpf_pkg::OP_ADD;
      q.chain_select = ch;
      q.src_ip = ($urandom_range(0, 2) == 0) ? 32'd0 : addr_pool[$urandom_range(0, 7)];
      q.dst_ip = ($urandom_range(0, 2) == 0) ? 32'd0 : addr_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 3))
         0: q.src_netmask = '1;
         1: q.src_netmask = 32'hFFFF_FF00;
         2: q.src_netmask = 32'hFFFF_0000;
         default: q.src_netmask = $urandom;
      endcase
      q.dst_netmask = ($urandom_range(0, 1) == 0) ? 32'hFF00_0000 : $urandom;
      q.proto_num = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 3) * 6);
      q.src_l4port = ($urandom_range(0, 2) != 0) ? 16'd0 : 16'($urandom_range(80, 83));
      q.dst_l4port = ($urandom_range(0, 2) != 0) ? 16'd0 : 16'($urandom_range(80, 83));
      return q;
   endfunction

   function automatic fmpf_pkg::req_type random_packet(logic [1:0] ch);
      fmpf_pkg::req_type q;
      q = random_bits();
      q.operation = fmpf_pkg::OP_CLASSIFY;
      q.chain_select = ch;
      if ($urandom_range(0, 3) != 0) begin
         q.src_ip = addr_pool[$urandom_range(0, 7)] ^ ($urandom & 32'h0000_00FF);
         q.dst_ip = addr_pool[$urandom_range(0, 7)] ^ ($urandom & 32'h00FF_FFFF);
         q.proto_num = 8'($urandom_range(1, 3) * 6);
         q.src_l4port = 16'($urandom_range(80, 83));
         q.dst_l4port = 16'($urandom_range(80, 83));
         q.has_ip_header = ($urandom_range(0, 7) != 0);
      end
      return q;
   endfunction

   // Receiver: random pops, with one long hold-off driven by the sender.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   initial begin
      fmpf_pkg::req_type q;
      for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: classifies on empty chains, then every chain gets a rule, with extremes and special cases.
      write_policy(fmpf_pkg::CSR_POLICY_INPUT, 1'b1);
      write_policy(fmpf_pkg::CSR_POLICY_OUTPUT, 1'b0);
      write_policy(fmpf_pkg::CSR_POLICY_FORWARD, 1'b1);
      q = '0; q.operation = fmpf_pkg::OP_CLASSIFY;
      for (int c = 0; c < 4; c++) begin
         q.chain_select = 2'(c);
         send_request(q);
      end
      q = '1; q.operation = fmpf_pkg::OP_ADD; q.chain_select = fmpf_pkg::CHAIN_INPUT;
      send_request(q);
      q.chain_select = fmpf_pkg::CHAIN_NONE; send_request(q);
      q = '1; q.operation = fmpf_pkg::OP_CLASSIFY; q.chain_select = fmpf_pkg::CHAIN_INPUT;
      send_request(q);
      q.has_transport = 1'b0; send_request(q);
      q.has_ip_header = 1'b0; send_request(q);
      q.chain_select = fmpf_pkg::CHAIN_NONE; q.has_ip_header = 1'b1; send_request(q);
      q = '0; q.operation = fmpf_pkg::OP_ADD; q.chain_select = fmpf_pkg::CHAIN_OUTPUT;
      q.rule_target = 1'b1;
      send_request(q);
      q = '0; q.operation = fmpf_pkg::OP_CLASSIFY; q.chain_select = fmpf_pkg::CHAIN_OUTPUT;
      q.has_ip_header = 1'b1; send_request(q);
      // Fill the forward chain past its end to see the chain-full status.
      for (int i = 0; i < RPC + 2; i++) send_request(random_add(fmpf_pkg::CHAIN_FORWARD));
      // Sender pauses until every expected response has come.
      wait_drained();

      // Random phases with changing policies; random adds fill the chains up to their size.
      for (int ph = 0; ph < 6; ph++) begin
         write_policy(fmpf_pkg::CSR_POLICY_INPUT, ph[0]);
         write_policy(fmpf_pkg::CSR_POLICY_OUTPUT, ph[1]);
         write_policy(fmpf_pkg::CSR_POLICY_FORWARD, ~ph[0]);
         if (ph == 2) hold_rsp = 1'b1;
         for (int i = 0; i < 200; i++) begin
            logic [1:0] ch;
            ch = ($urandom_range(0, 15) == 0) ? fmpf_pkg::CHAIN_NONE :
                 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
               0, 1: q = random_add(ch);
               2: q = random_bits();
               default: q = random_packet(ch);
            endcase
            send_request(q, (ph == 2));
         end
         wait_drained();
      end

      stop_push();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_first_match_packet_filter: done, clean");
      else
         $display("tb_first_match_packet_filter: done, errors");
      $finish;
   end
endmodule
